// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== src/ipcd_pkg.sv =====
// shared types, direction codes and helpers for the plot command decoder
package ipcd_pkg;

  // direction codes, bits 6:3 of a command byte
  localparam logic [3:0] DIR_NONE     = 4'd0;
  localparam logic [3:0] DIR_EAST     = 4'd1;
  localparam logic [3:0] DIR_WEST     = 4'd2;
  localparam logic [3:0] DIR_EW       = 4'd3;
  localparam logic [3:0] DIR_NORTH    = 4'd4;
  localparam logic [3:0] DIR_EWN      = 4'd7;
  localparam logic [3:0] DIR_SOUTH    = 4'd8;
  localparam logic [3:0] DIR_EWS      = 4'd11;
  localparam logic [3:0] DIR_PEN_DOWN = 4'd12;
  localparam logic [3:0] DIR_NOP      = 4'd13;
  localparam logic [3:0] DIR_PEN_UP   = 4'd14;
  localparam logic [3:0] DIR_ALL      = 4'd15;

  localparam int BYTE_W     = 8;
  localparam int FIELD_W    = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_OFFSET_X = 1'b0,
    REG_OFFSET_Y = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_bad(input logic [3:0] dir);
    logic bad;
    unique case (dir) inside
      DIR_NONE, DIR_EW, DIR_EWN, DIR_EWS, DIR_ALL: bad = 1'b1;
      default:                                     bad = 1'b0;
    endcase
    return bad;
  endfunction

endpackage

// ===== src/ipcd_in_if.sv =====
// plot byte input channel
interface ipcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// ===== src/ipcd_out_if.sv =====
// decoded command result channel
interface ipcd_out_if;
  logic               valid;
  logic               ready;
  logic               bad_command;
  logic [3:0]         direction;
  logic [23:0]        step_count;
  logic signed [23:0] out_x;
  logic signed [23:0] out_y;
  logic               pen_down;
  logic [1:0]         path_action;
  logic               ink_seen;
  logic signed [23:0] ink_x_min;
  logic signed [23:0] ink_x_max;
  logic signed [23:0] ink_y_min;
  logic signed [23:0] ink_y_max;

  modport source (
    output valid, output bad_command, output direction, output step_count,
    output out_x, output out_y, output pen_down, output path_action,
    output ink_seen, output ink_x_min, output ink_x_max, output ink_y_min,
    output ink_y_max, input ready
  );
  modport sink (
    input valid, input bad_command, input direction, input step_count,
    input out_x, input out_y, input pen_down, input path_action,
    input ink_seen, input ink_x_min, input ink_x_max, input ink_y_min,
    input ink_y_max, output ready
  );
endinterface

// ===== src/incremental_plotter_command_decoder.sv =====
// top level of the incremental plotter command decoder
// Takes one plot stream byte per cycle while the command queue has room
// and returns one result per command byte (prefix bytes only extend the
// count). The front accumulates count prefixes and classifies commands
// into a two-entry queue; the back runs each command through an execute
// register (pen move with saturation) and a report register (bounding box
// and offset), so one byte per clock holds while results are taken. The
// output register lets a new byte be taken while a result waits. The
// offsets sit at byte addresses 0 and 4 of the config port and should be
// written while the decoder is idle.
`include "assert_macros.svh"

module incremental_plotter_command_decoder #(
  parameter int COUNT_BITS = 24,
  parameter int POS_BITS   = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ipcd_in_if.sink                             in_if,
  ipcd_out_if.source                          out_if,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ipcd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ipcd_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ipcd_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int CMD_W = COUNT_BITS + 5;

  logic signed [23:0]     off_x_r, off_y_r;
  ipcd_pkg::reg_idx_t     reg_idx;
  logic                   cfg_wr;

  logic                   q_push, q_pop;
  logic [CMD_W-1:0]       q_push_data, q_head;
  ipcd_pkg::q_stat_t      q_stat;
  logic                   prefix_acc;

  assign reg_idx    = ipcd_pkg::reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (reg_idx)
      ipcd_pkg::REG_OFFSET_X: cfg_prdata = 32'(off_x_r);
      ipcd_pkg::REG_OFFSET_Y: cfg_prdata = 32'(off_y_r);
      default:                cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ipcd_pkg::REG_OFFSET_X: off_x_r <= cfg_pwdata[23:0];
        ipcd_pkg::REG_OFFSET_Y: off_y_r <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  ipcd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .q_full    (q_stat.full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  ipcd_queue #(
    .WIDTH(CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  ipcd_back #(
    .COUNT_BITS(COUNT_BITS),
    .POS_BITS  (POS_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (!q_stat.empty),
    .q_data   (q_head),
    .pop      (q_pop),
    .offset_x (off_x_r),
    .offset_y (off_y_r),
    .out_if   (out_if)
  );

  assign prefix_acc = in_if.valid && in_if.ready && in_if.byte_in[7];

  `ASSERT_IMP(a_push_room, clk, rst_n, q_push, !q_stat.full, "command queue overflow")
  `ASSERT_IMP(a_pop_data, clk, rst_n, q_pop, !q_stat.empty, "command queue underflow")
  `ASSERT_IMP(a_prefix_no_cmd, clk, rst_n, prefix_acc, !q_push, "prefix byte queued")
  `ASSERT_NEVER(a_queue_state, clk, rst_n, q_stat.full && q_stat.empty, "queue full and empty")

endmodule

// ===== src/ipcd_front.sv =====
// front end: count prefix accumulation and command classification
module ipcd_front #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ipcd_in_if.sink               in_if,
  input  logic                  q_full,
  output logic                  push,
  output logic [COUNT_BITS+4:0] push_data
);

  localparam int CW       = COUNT_BITS;
  localparam int BYTE_MSB = ipcd_pkg::BYTE_W - 1;

  logic [CW-1:0] acc_r;
  logic [CW-1:0] acc_nxt;
  logic [CW+6:0] pre_wide;
  logic [CW+2:0] cmd_wide;
  logic [CW-1:0] count;
  logic [3:0]    dir;
  logic          accept;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;

  assign pre_wide = {acc_r, in_if.byte_in[6:0]};
  assign cmd_wide = {acc_r, in_if.byte_in[2:0]};
  assign dir      = in_if.byte_in[6:3];

  // saturate when bits would fall off the top
  always_comb begin
    if (|pre_wide[CW+6:CW]) begin
      acc_nxt = '1;
    end else begin
      acc_nxt = pre_wide[CW-1:0];
    end
    if (|cmd_wide[CW+2:CW]) begin
      count = '1;
    end else begin
      count = cmd_wide[CW-1:0];
    end
  end

  assign push      = accept && !in_if.byte_in[BYTE_MSB];
  assign push_data = {ipcd_pkg::is_bad(dir), dir, count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (accept) begin
      if (in_if.byte_in[BYTE_MSB]) begin
        acc_r <= acc_nxt;
      end else begin
        acc_r <= '0;
      end
    end
  end

endmodule

// ===== src/ipcd_queue.sv =====
// short command queue between front and back
module ipcd_queue #(
  parameter int WIDTH = 29
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output ipcd_pkg::q_stat_t stat
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/ipcd_back.sv =====
// back end: pen motion, bounding box, offset and result register
module ipcd_back #(
  parameter int COUNT_BITS = 24,
  parameter int POS_BITS   = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  logic [COUNT_BITS+4:0] q_data,
  output logic                  pop,
  input  logic signed [23:0]    offset_x,
  input  logic signed [23:0]    offset_y,
  ipcd_out_if.source            out_if
);

  localparam int CW = COUNT_BITS;
  localparam int PW = POS_BITS;
  localparam int SW = ((PW > CW + 1) ? PW : CW + 1) + 2;
  localparam int OW = ((PW > ipcd_pkg::FIELD_W) ? PW : ipcd_pkg::FIELD_W) + 1;

  localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_MOVETO = 2'd1,
    ACT_LINETO = 2'd2,
    ACT_STROKE = 2'd3
  } act_t;

  typedef struct packed {
    logic                 bad;
    logic [3:0]           dir;
    logic [CW-1:0]        count;
    logic signed [PW-1:0] pen_x;
    logic signed [PW-1:0] pen_y;
    logic                 pen_down;
    act_t                 action;
    logic                 ink;
  } exec_t;

  // ---------------- execute stage ----------------
  logic                 a_v_r;
  exec_t                a_r;
  exec_t                a_nxt;
  logic                 b_adv;
  logic signed [PW-1:0] pen_x_r, pen_y_r;
  logic signed [PW-1:0] pen_x_nxt, pen_y_nxt;
  logic                 pen_down_r, pen_down_nxt;

  logic                 q_bad;
  logic [3:0]           q_dir;
  logic [CW-1:0]        q_count;
  logic                 good, is_move;
  logic [CW:0]          cnt1;
  logic signed [SW-1:0] step_s, x_sum, y_sum;
  logic signed [PW-1:0] x_sat, y_sat;

  assign q_bad   = q_data[CW+4];
  assign q_dir   = q_data[CW+3:CW];
  assign q_count = q_data[CW-1:0];

  assign b_adv = a_v_r && (!out_if.valid || out_if.ready);
  assign pop   = q_valid && (!a_v_r || b_adv);

  assign good    = !q_bad && (q_dir != ipcd_pkg::DIR_NOP);
  assign is_move = (q_dir != ipcd_pkg::DIR_PEN_DOWN) && (q_dir != ipcd_pkg::DIR_PEN_UP);
  assign cnt1    = {1'b0, q_count} + (CW+1)'(1);
  assign step_s  = SW'(cnt1);

  // at most one x and one y bit is set on a good move
  assign x_sum = SW'(pen_x_r) + (q_dir[1] ? -step_s : step_s);
  assign y_sum = SW'(pen_y_r) + (q_dir[3] ? -step_s : step_s);

  always_comb begin
    if (x_sum > SW'(POS_MAX)) begin
      x_sat = POS_MAX;
    end else if (x_sum < SW'(POS_MIN)) begin
      x_sat = POS_MIN;
    end else begin
      x_sat = PW'(x_sum);
    end
    if (y_sum > SW'(POS_MAX)) begin
      y_sat = POS_MAX;
    end else if (y_sum < SW'(POS_MIN)) begin
      y_sat = POS_MIN;
    end else begin
      y_sat = PW'(y_sum);
    end
  end

  always_comb begin
    pen_x_nxt    = pen_x_r;
    pen_y_nxt    = pen_y_r;
    pen_down_nxt = pen_down_r;
    if (good) begin
      if (q_dir == ipcd_pkg::DIR_PEN_DOWN) begin
        pen_down_nxt = 1'b1;
      end else if (q_dir == ipcd_pkg::DIR_PEN_UP) begin
        pen_down_nxt = 1'b0;
      end
      if (is_move && (q_dir[0] || q_dir[1])) begin
        pen_x_nxt = x_sat;
      end
      if (is_move && (q_dir[2] || q_dir[3])) begin
        pen_y_nxt = y_sat;
      end
    end

    a_nxt.bad      = q_bad;
    a_nxt.dir      = q_dir;
    a_nxt.count    = q_count;
    a_nxt.pen_x    = pen_x_nxt;
    a_nxt.pen_y    = pen_y_nxt;
    a_nxt.pen_down = pen_down_nxt;
    a_nxt.ink      = good && pen_down_nxt;
    if (!good) begin
      a_nxt.action = ACT_NONE;
    end else if (pen_down_nxt != pen_down_r) begin
      a_nxt.action = pen_down_nxt ? ACT_MOVETO : ACT_STROKE;
    end else begin
      a_nxt.action = pen_down_nxt ? ACT_LINETO : ACT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r      <= 1'b0;
      pen_x_r    <= '0;
      pen_y_r    <= '0;
      pen_down_r <= 1'b0;
    end else begin
      if (pop) begin
        a_v_r      <= 1'b1;
        pen_x_r    <= pen_x_nxt;
        pen_y_r    <= pen_y_nxt;
        pen_down_r <= pen_down_nxt;
      end else if (b_adv) begin
        a_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_r <= a_nxt;
    end
  end

  // ---------------- box and report stage ----------------
  logic                 out_v_r;
  logic                 ink_r;
  logic signed [PW-1:0] xl_r, xh_r, yl_r, yh_r;
  logic signed [PW-1:0] xl_nxt, xh_nxt, yl_nxt, yh_nxt;
  logic signed [OW-1:0] ox_sum, oy_sum;
  logic signed [PW-1:0] ox_sat, oy_sat;

  logic                 bad_r;
  logic [3:0]           dir_r;
  logic [23:0]          step_r;
  logic signed [23:0]   ox_r, oy_r;
  logic                 pdown_r;
  act_t                 act_r;
  logic                 seen_r;
  logic signed [23:0]   bxl_r, bxh_r, byl_r, byh_r;

  always_comb begin
    xl_nxt = xl_r;
    xh_nxt = xh_r;
    yl_nxt = yl_r;
    yh_nxt = yh_r;
    if (a_r.ink) begin
      if (a_r.pen_x < xl_r) xl_nxt = a_r.pen_x;
      if (a_r.pen_x > xh_r) xh_nxt = a_r.pen_x;
      if (a_r.pen_y < yl_r) yl_nxt = a_r.pen_y;
      if (a_r.pen_y > yh_r) yh_nxt = a_r.pen_y;
    end
  end

  assign ox_sum = OW'(a_r.pen_x) + OW'(offset_x);
  assign oy_sum = OW'(a_r.pen_y) + OW'(offset_y);

  always_comb begin
    if (ox_sum > OW'(POS_MAX)) begin
      ox_sat = POS_MAX;
    end else if (ox_sum < OW'(POS_MIN)) begin
      ox_sat = POS_MIN;
    end else begin
      ox_sat = PW'(ox_sum);
    end
    if (oy_sum > OW'(POS_MAX)) begin
      oy_sat = POS_MAX;
    end else if (oy_sum < OW'(POS_MIN)) begin
      oy_sat = POS_MIN;
    end else begin
      oy_sat = PW'(oy_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      ink_r   <= 1'b0;
      xl_r    <= POS_MAX;
      xh_r    <= POS_MIN;
      yl_r    <= POS_MAX;
      yh_r    <= POS_MIN;
    end else begin
      if (b_adv) begin
        out_v_r <= 1'b1;
        ink_r   <= ink_r || a_r.ink;
        xl_r    <= xl_nxt;
        xh_r    <= xh_nxt;
        yl_r    <= yl_nxt;
        yh_r    <= yh_nxt;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      bad_r   <= a_r.bad;
      dir_r   <= a_r.dir;
      step_r  <= 24'(a_r.count);
      ox_r    <= 24'(ox_sat);
      oy_r    <= 24'(oy_sat);
      pdown_r <= a_r.pen_down;
      act_r   <= a_r.action;
      seen_r  <= ink_r || a_r.ink;
      bxl_r   <= 24'(xl_nxt);
      bxh_r   <= 24'(xh_nxt);
      byl_r   <= 24'(yl_nxt);
      byh_r   <= 24'(yh_nxt);
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.bad_command = bad_r;
  assign out_if.direction   = dir_r;
  assign out_if.step_count  = step_r;
  assign out_if.out_x       = ox_r;
  assign out_if.out_y       = oy_r;
  assign out_if.pen_down    = pdown_r;
  assign out_if.path_action = act_r;
  assign out_if.ink_seen    = seen_r;
  assign out_if.ink_x_min   = bxl_r;
  assign out_if.ink_x_max   = bxh_r;
  assign out_if.ink_y_min   = byl_r;
  assign out_if.ink_y_max   = byh_r;

endmodule
